// ===== rtl/core/dbtu_pkg.sv =====
// Shared constants and types for the routing bucket table.
package dbtu_pkg;

  localparam int ENTRIES_PER_BUCKET = 10;
  localparam int BUCKET_COUNT       = 3;
  localparam int ID_BITS            = 16;

  localparam int DEPTH  = ENTRIES_PER_BUCKET * BUCKET_COUNT;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IDX_W  = (ENTRIES_PER_BUCKET > 1) ? $clog2(ENTRIES_PER_BUCKET) : 1;
  localparam int BKT_W  = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;

  // Result codes
  typedef enum logic [2:0] {
    STATUS_SELF      = 3'd0,
    STATUS_PRESENT   = 3'd1,
    STATUS_INSERTED  = 3'd2,
    STATUS_REPLACED  = 3'd3,
    STATUS_REJECTED  = 3'd4,
    STATUS_DELETED   = 3'd5,
    STATUS_NOT_FOUND = 3'd6
  } status_t;

  // Operation codes of the mode field
  localparam logic MODE_UPDATE = 1'b0;
  localparam logic MODE_DELETE = 1'b1;

endpackage

// ===== rtl/core/dht_bucket_table_update.sv =====
// Routing bucket table: node id memory, valid marks and the scan sequencer.
//
// Three buckets of ten 16-bit node ids sit in one synchronous memory (one read,
// one write port), with a valid mark per slot held in flip-flops. Each input
// word is handled on its own: the sequencer reads the slots one per cycle
// through the memory read port and compares them in the following cycle, then
// writes back once. An update to a valid bucket reads its ten slots, drains the
// last compare and writes back; a delete walks all thirty slots. An update
// naming the own id or a bucket outside the table skips the scan and goes
// straight to the result. A new word is taken only once the sequencer is back
// in idle. The result sits in an output register, so the next word is accepted
// while it waits; that word holds at write-back until the register is free.
// No clearing pass is needed after reset.
module dht_bucket_table_update (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          cfg_wr_en,
  input  logic [dbtu_pkg::ID_BITS-1:0]  cfg_wr_data,
  // input words
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_mode,
  input  logic [dbtu_pkg::ID_BITS-1:0]  in_node_id,
  input  logic [1:0]                    in_bucket_index,
  // result words
  output logic                          out_valid,
  input  logic                          out_stall,
  output dbtu_pkg::status_t             out_status,
  output logic [dbtu_pkg::ID_BITS-1:0]  out_evicted_id
);
  import dbtu_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic [ID_BITS-1:0] own_id_r;
  logic [DEPTH-1:0]   valid_r;

  // id memory
  logic [ID_BITS-1:0] mem [DEPTH];
  logic [ID_BITS-1:0] rd_data_r;
  logic [ADDR_W-1:0]  rd_addr;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;

  // current word
  logic               mode_r;
  logic [ID_BITS-1:0] node_r;
  logic               pre_r;
  status_t            pre_status_r;

  // scan counters and compare stage
  logic [IDX_W-1:0]   idx_r;
  logic [BKT_W-1:0]   bkt_r;
  logic               issue_done_r;
  logic               last_issue;
  logic               cmp_vld_r;
  logic               cmp_last_r;
  logic [ADDR_W-1:0]  cmp_addr_r;
  logic               cmp_hit;
  logic [ID_BITS-1:0] cmp_dist;

  // scan findings
  logic               found_r;
  logic [ADDR_W-1:0]  found_addr_r;
  logic               empty_found_r;
  logic [ADDR_W-1:0]  empty_addr_r;
  logic               vict_found_r;
  logic [ADDR_W-1:0]  vict_addr_r;
  logic [ID_BITS-1:0] vict_id_r;
  logic [ID_BITS-1:0] far_r;

  // output register
  logic               out_valid_r;
  status_t            out_status_r;
  logic [ID_BITS-1:0] out_evicted_id_r;

  logic               in_fire;
  logic               done_fire;

  assign in_stall       = (state_r != ST_IDLE);
  assign in_fire        = in_valid && !in_stall;
  assign done_fire      = (state_r == ST_DONE) && (!out_valid_r || !out_stall);
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_evicted_id = out_evicted_id_r;

  // Slot address: bucket times bucket size plus slot index
  assign rd_addr = ADDR_W'(ADDR_W'(bkt_r) * ADDR_W'(ENTRIES_PER_BUCKET)) + ADDR_W'(idx_r);

  assign last_issue = (idx_r == IDX_W'(ENTRIES_PER_BUCKET - 1)) &&
                      ((mode_r == MODE_UPDATE) || (bkt_r == BKT_W'(BUCKET_COUNT - 1)));

  assign cmp_hit  = cmp_vld_r && valid_r[cmp_addr_r] && (rd_data_r == node_r);
  assign cmp_dist = rd_data_r ^ own_id_r;

  // Write back a new id on insert or replace
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = empty_addr_r;
    if (done_fire && !pre_r && (mode_r == MODE_UPDATE) && !found_r) begin
      if (empty_found_r) begin
        wr_en = 1'b1;
      end else if (vict_found_r) begin
        wr_en   = 1'b1;
        wr_addr = vict_addr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
    if (wr_en) begin
      mem[wr_addr] <= node_r;
    end
  end

  // Sequence: accept, scan, write back
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if ((in_mode == MODE_UPDATE) &&
              ((in_node_id == own_id_r) || (int'(in_bucket_index) >= BUCKET_COUNT))) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (cmp_vld_r && cmp_last_r) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (done_fire) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      own_id_r     <= '0;
      valid_r      <= '0;
      issue_done_r <= 1'b0;
      cmp_vld_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;

      // take configuration
      if (cfg_wr_en) begin
        own_id_r <= cfg_wr_data;
      end

      // load a new word and clear findings
      if (in_fire) begin
        mode_r        <= in_mode;
        node_r        <= in_node_id;
        bkt_r         <= (in_mode == MODE_UPDATE) ? BKT_W'(in_bucket_index) : '0;
        idx_r         <= '0;
        issue_done_r  <= 1'b0;
        found_r       <= 1'b0;
        empty_found_r <= 1'b0;
        vict_found_r  <= 1'b0;
        far_r         <= in_node_id ^ own_id_r;
        if ((in_mode == MODE_UPDATE) && (in_node_id == own_id_r)) begin
          pre_r        <= 1'b1;
          pre_status_r <= STATUS_SELF;
        end else if ((in_mode == MODE_UPDATE) && (int'(in_bucket_index) >= BUCKET_COUNT)) begin
          pre_r        <= 1'b1;
          pre_status_r <= STATUS_REJECTED;
        end else begin
          pre_r        <= 1'b0;
          pre_status_r <= STATUS_REJECTED;
        end
      end

      // advance read issue
      cmp_vld_r <= (state_r == ST_SCAN) && !issue_done_r;
      if ((state_r == ST_SCAN) && !issue_done_r) begin
        cmp_addr_r <= rd_addr;
        cmp_last_r <= last_issue;
        if (last_issue) begin
          issue_done_r <= 1'b1;
        end else if ((mode_r == MODE_DELETE) && (bkt_r != BKT_W'(BUCKET_COUNT - 1))) begin
          bkt_r <= bkt_r + 1'b1;
        end else begin
          bkt_r <= (mode_r == MODE_DELETE) ? '0 : bkt_r;
          idx_r <= idx_r + 1'b1;
        end
      end

      // compare the slot just read
      if (cmp_vld_r) begin
        if (cmp_hit && !found_r) begin
          found_r      <= 1'b1;
          found_addr_r <= cmp_addr_r;
        end
        if (!valid_r[cmp_addr_r] && !empty_found_r) begin
          empty_found_r <= 1'b1;
          empty_addr_r  <= cmp_addr_r;
        end
        if (cmp_dist > far_r) begin
          far_r        <= cmp_dist;
          vict_found_r <= 1'b1;
          vict_addr_r  <= cmp_addr_r;
          vict_id_r    <= rd_data_r;
        end
      end

      // write back and hand the result over, else drop a taken result
      if (done_fire) begin
        out_valid_r <= 1'b1;
        if (pre_r) begin
          out_status_r     <= pre_status_r;
          out_evicted_id_r <= '0;
        end else if (mode_r == MODE_DELETE) begin
          out_evicted_id_r <= '0;
          if (found_r) begin
            valid_r[found_addr_r] <= 1'b0;
            out_status_r          <= STATUS_DELETED;
          end else begin
            out_status_r <= STATUS_NOT_FOUND;
          end
        end else if (found_r) begin
          out_status_r     <= STATUS_PRESENT;
          out_evicted_id_r <= '0;
        end else if (empty_found_r) begin
          valid_r[empty_addr_r] <= 1'b1;
          out_status_r          <= STATUS_INSERTED;
          out_evicted_id_r      <= '0;
        end else if (vict_found_r) begin
          out_status_r     <= STATUS_REPLACED;
          out_evicted_id_r <= vict_id_r;
        end else begin
          out_status_r     <= STATUS_REJECTED;
          out_evicted_id_r <= '0;
        end
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule
